>>> hw/rtl/radial_stick_dead_zone_core_defines.svh
// assertion macros for the radial stick dead-zone core
// used by the top level only; no other dependencies
`ifndef RADIAL_STICK_DEAD_ZONE_CORE_DEFINES_SVH
`define RADIAL_STICK_DEAD_ZONE_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define RSDZ_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define RSDZ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) ante |=> cons) else $error(msg);
`else
`define RSDZ_ASSERT(label, prop, msg)
`define RSDZ_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

>>> hw/rtl/rsdz_pkg.sv
// shared constants, sideband types and helpers for the radial dead-zone core
// no dependencies
`default_nettype none
package rsdz_pkg;
	localparam int OUT_FRAC_BITS = 15;
	localparam int NORM_BITS     = 30;
	localparam int QSHIFT        = NORM_BITS - OUT_FRAC_BITS;
	localparam int QW            = OUT_FRAC_BITS + 1;
	localparam int SQ_STEPS      = 32;
	localparam int RD_STEPS      = NORM_BITS + 1;
	localparam logic [NORM_BITS:0] NORM_ONE = (NORM_BITS+1)'(1) << NORM_BITS;
	localparam logic [NORM_BITS:0] NORM_MUL = (NORM_BITS+1)'(32769);

	typedef struct packed {
		logic [NORM_BITS:0] ax;
		logic [NORM_BITS:0] ay;
		logic               neg_x;
		logic               neg_y;
		logic [NORM_BITS:0] dz;
	} sq_side_t;

	typedef struct packed {
		logic [NORM_BITS:0] ax;
		logic [NORM_BITS:0] ay;
		logic               neg_x;
		logic               neg_y;
		logic               zero;
		logic [NORM_BITS:0] mag;
	} rd_side_t;

	typedef struct packed {
		logic neg;
		logic zero;
	} ax_side_t;

	// for non-negative raw, raw * 2^30 / 32767 is raw * 32769 plus one at full scale
	function automatic logic [NORM_BITS:0] norm_axis(input logic [15:0] raw);
		logic [16:0]        mag;
		logic [NORM_BITS:0] res;
		mag = 17'h10000 - {1'b0, raw};
		if (raw[15]) begin
			res = (NORM_BITS+1)'(mag) << 15;
		end else begin
			res = (NORM_BITS+1)'(raw[14:0]) * NORM_MUL
				+ (NORM_BITS+1)'(raw[14:0] == 15'h7fff);
		end
		return res;
	endfunction

	function automatic logic [15:0] sat_out(input logic [QW-1:0] q, input logic neg,
		input logic zero);
		logic [31:0] qe;
		logic [15:0] res;
		qe = 32'(q);
		if (zero) begin
			res = '0;
		end else if (neg) begin
			res = (qe > 32'd32768) ? 16'h8000 : 16'(32'd0 - qe);
		end else begin
			res = (qe > 32'd32767) ? 16'h7fff : qe[15:0];
		end
		return res;
	endfunction
endpackage
`default_nettype wire

>>> hw/rtl/rsdz_sqrt.sv
// pipelined integer square root, one result bit per stage
// depends on rsdz_pkg
`default_nettype none
module rsdz_sqrt import rsdz_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 adv,
	input  wire logic                 in_valid,
	input  wire logic [61:0]          in_s,
	input  wire sq_side_t             in_side,
	output logic                      res_valid,
	output logic [NORM_BITS:0]        res_mag,
	output sq_side_t                  res_side
);
	logic [63:0] v_s    [0:SQ_STEPS-1];
	logic [63:0] r_s    [0:SQ_STEPS-1];
	logic        val_s  [0:SQ_STEPS-1];
	sq_side_t    side_s [0:SQ_STEPS-1];

	for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
		localparam logic [63:0] BIT = 64'd1 << (62 - 2*k);
		logic [63:0] v_prev;
		logic [63:0] r_prev;
		logic        val_prev;
		sq_side_t    side_prev;
		logic [63:0] sum;
		logic        take;

		if (k == 0) begin : g_first
			assign v_prev    = 64'(in_s);
			assign r_prev    = '0;
			assign val_prev  = in_valid;
			assign side_prev = in_side;
		end else begin : g_next
			assign v_prev    = v_s[k-1];
			assign r_prev    = r_s[k-1];
			assign val_prev  = val_s[k-1];
			assign side_prev = side_s[k-1];
		end

		assign sum  = r_prev + BIT;
		assign take = v_prev >= sum;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				val_s[k] <= 1'b0;
			end else if (adv) begin
				val_s[k] <= val_prev;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				v_s[k]    <= take ? v_prev - sum : v_prev;
				r_s[k]    <= take ? (r_prev >> 1) + BIT : r_prev >> 1;
				side_s[k] <= side_prev;
			end
		end
	end

	assign res_valid = val_s[SQ_STEPS-1];
	assign res_mag   = r_s[SQ_STEPS-1][NORM_BITS:0];
	assign res_side  = side_s[SQ_STEPS-1];
endmodule
`default_nettype wire

>>> hw/rtl/rsdz_ring_div.sv
// pipelined restoring divider for the live-ring scale, one quotient bit per stage
// depends on rsdz_pkg
`default_nettype none
module rsdz_ring_div import rsdz_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 adv,
	input  wire logic                 in_valid,
	input  wire logic [61:0]          in_num,
	input  wire logic [NORM_BITS:0]   in_den,
	input  wire rd_side_t             in_side,
	output logic                      res_valid,
	output logic [NORM_BITS:0]        res_q,
	output rd_side_t                  res_side
);
	logic [61:0]        rem_s  [0:RD_STEPS-1];
	logic [NORM_BITS:0] den_s  [0:RD_STEPS-1];
	logic [NORM_BITS:0] q_s    [0:RD_STEPS-1];
	logic               val_s  [0:RD_STEPS-1];
	rd_side_t           side_s [0:RD_STEPS-1];

	for (genvar k = 0; k < RD_STEPS; k++) begin : g_step
		localparam int SH = RD_STEPS - 1 - k;
		logic [61:0]        rem_prev;
		logic [NORM_BITS:0] den_prev;
		logic [NORM_BITS:0] q_prev;
		logic               val_prev;
		rd_side_t           side_prev;
		logic [61:0]        dsh;
		logic               take;

		if (k == 0) begin : g_first
			assign rem_prev  = in_num;
			assign den_prev  = in_den;
			assign q_prev    = '0;
			assign val_prev  = in_valid;
			assign side_prev = in_side;
		end else begin : g_next
			assign rem_prev  = rem_s[k-1];
			assign den_prev  = den_s[k-1];
			assign q_prev    = q_s[k-1];
			assign val_prev  = val_s[k-1];
			assign side_prev = side_s[k-1];
		end

		assign dsh  = 62'(den_prev) << SH;
		assign take = rem_prev >= dsh;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				val_s[k] <= 1'b0;
			end else if (adv) begin
				val_s[k] <= val_prev;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[k]  <= take ? rem_prev - dsh : rem_prev;
				den_s[k]  <= den_prev;
				q_s[k]    <= {q_prev[NORM_BITS-1:0], take};
				side_s[k] <= side_prev;
			end
		end
	end

	assign res_valid = val_s[RD_STEPS-1];
	assign res_q     = q_s[RD_STEPS-1];
	assign res_side  = side_s[RD_STEPS-1];
endmodule
`default_nettype wire

>>> hw/rtl/rsdz_axis_div.sv
// pipelined divider for one axis: (|n| * scale) / (mag << shift), top bits only
// depends on rsdz_pkg
`default_nettype none
module rsdz_axis_div import rsdz_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 adv,
	input  wire logic                 in_valid,
	input  wire logic [61:0]          in_prod,
	input  wire logic [NORM_BITS:0]   in_mag,
	input  wire ax_side_t             in_side,
	output logic                      res_valid,
	output logic [QW-1:0]             res_q,
	output ax_side_t                  res_side
);
	logic [61:0]   rem_s  [0:QW-1];
	logic [61:0]   dv_s   [0:QW-1];
	logic [QW-1:0] q_s    [0:QW-1];
	logic          val_s  [0:QW-1];
	ax_side_t      side_s [0:QW-1];

	for (genvar k = 0; k < QW; k++) begin : g_step
		localparam int SH = QW - 1 - k;
		logic [61:0]   rem_prev;
		logic [61:0]   dv_prev;
		logic [QW-1:0] q_prev;
		logic          val_prev;
		ax_side_t      side_prev;
		logic [61:0]   dsh;
		logic          take;

		if (k == 0) begin : g_first
			assign rem_prev  = in_prod;
			assign dv_prev   = 62'(in_mag) << QSHIFT;
			assign q_prev    = '0;
			assign val_prev  = in_valid;
			assign side_prev = in_side;
		end else begin : g_next
			assign rem_prev  = rem_s[k-1];
			assign dv_prev   = dv_s[k-1];
			assign q_prev    = q_s[k-1];
			assign val_prev  = val_s[k-1];
			assign side_prev = side_s[k-1];
		end

		assign dsh  = dv_prev << SH;
		assign take = rem_prev >= dsh;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				val_s[k] <= 1'b0;
			end else if (adv) begin
				val_s[k] <= val_prev;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[k]  <= take ? rem_prev - dsh : rem_prev;
				dv_s[k]   <= dv_prev;
				q_s[k]    <= {q_prev[QW-2:0], take};
				side_s[k] <= side_prev;
			end
		end
	end

	assign res_valid = val_s[QW-1];
	assign res_q     = q_s[QW-1];
	assign res_side  = side_s[QW-1];
endmodule
`default_nettype wire

>>> hw/rtl/radial_stick_dead_zone_core.sv
// top level of the radial stick dead-zone core
// depends on rsdz_pkg, rsdz_sqrt, rsdz_ring_div, rsdz_axis_div and the defines header
`default_nettype none
`include "radial_stick_dead_zone_core_defines.svh"
// Takes one stick sample (signed x, y) and a dead-zone radius per beat and returns the
// normalised, dead-zone-corrected x and y in Q1.15, truncated toward zero and saturated.
// A new sample is accepted every cycle while stick_stall is low; each beat passes from
// input to output through the 32-stage square root, the 31-stage ring-scale divider
// and the OUT_FRAC_BITS+1 stage axis dividers. The whole pipeline freezes only while a
// result sits in the output register and out_stall is high.
module radial_stick_dead_zone_core import rsdz_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        stick_valid,
	output logic             stick_stall,
	input  wire logic [15:0] stick_x,
	input  wire logic [15:0] stick_y,
	input  wire logic [14:0] dead_zone,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [15:0]      out_x,
	output logic [15:0]      out_y
);
	logic adv;

	logic               val_s1;
	logic [NORM_BITS:0] ax_s1;
	logic [NORM_BITS:0] ay_s1;
	logic               negx_s1;
	logic               negy_s1;
	logic [NORM_BITS:0] dz_s1;

	logic        val_s2;
	logic [61:0] sqx_s2;
	logic [61:0] sqy_s2;
	sq_side_t    side_s2;

	logic        val_s3;
	logic [61:0] sum_s3;
	sq_side_t    side_s3;

	logic               sq_valid;
	logic [NORM_BITS:0] mag_raw;
	sq_side_t           sq_side;

	logic               magc_big;
	logic [NORM_BITS:0] magc;
	logic               in_dz;

	logic               val_s4;
	logic [61:0]        num_s4;
	logic [NORM_BITS:0] den_s4;
	rd_side_t           rside_s4;

	logic               rd_valid;
	logic [NORM_BITS:0] sm;
	rd_side_t           rd_side;

	logic               val_s5;
	logic [61:0]        px_s5;
	logic [61:0]        py_s5;
	logic [NORM_BITS:0] mag_s5;
	ax_side_t           xside_s5;
	ax_side_t           yside_s5;

	logic          ax_valid;
	logic [QW-1:0] qx;
	ax_side_t      xs_out;
	logic          ay_valid;
	logic [QW-1:0] qy;
	ax_side_t      ys_out;

	logic        out_valid_s6;
	logic [15:0] out_x_s6;
	logic [15:0] out_y_s6;

	// everything moves unless a finished beat is held at the output
	assign adv         = !(out_valid_s6 && out_stall);
	assign stick_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_s1       <= 1'b0;
			val_s2       <= 1'b0;
			val_s3       <= 1'b0;
			val_s4       <= 1'b0;
			val_s5       <= 1'b0;
			out_valid_s6 <= 1'b0;
		end else if (adv) begin
			val_s1       <= stick_valid;
			val_s2       <= val_s1;
			val_s3       <= val_s2;
			val_s4       <= sq_valid;
			val_s5       <= rd_valid;
			out_valid_s6 <= ax_valid;
		end
	end

	// normalise both axes and the dead-zone radius to Q1.30
	always_ff @(posedge clk) begin
		if (adv) begin
			ax_s1   <= norm_axis(stick_x);
			ay_s1   <= norm_axis(stick_y);
			negx_s1 <= stick_x[15];
			negy_s1 <= stick_y[15];
			dz_s1   <= norm_axis({1'b0, dead_zone});
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sqx_s2        <= 62'(ax_s1) * 62'(ax_s1);
			sqy_s2        <= 62'(ay_s1) * 62'(ay_s1);
			side_s2.ax    <= ax_s1;
			side_s2.ay    <= ay_s1;
			side_s2.neg_x <= negx_s1;
			side_s2.neg_y <= negy_s1;
			side_s2.dz    <= dz_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s3  <= sqx_s2 + sqy_s2;
			side_s3 <= side_s2;
		end
	end

	rsdz_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (val_s3),
		.in_s      (sum_s3),
		.in_side   (side_s3),
		.res_valid (sq_valid),
		.res_mag   (mag_raw),
		.res_side  (sq_side)
	);

	// clamp to unit length, then set up (mag - dz) * 2^30 / (2^30 - dz)
	assign magc_big = mag_raw > NORM_ONE;
	assign magc     = magc_big ? NORM_ONE : mag_raw;
	assign in_dz    = magc <= sq_side.dz;

	always_ff @(posedge clk) begin
		if (adv) begin
			num_s4         <= in_dz ? 62'd0 : 62'(magc - sq_side.dz) << NORM_BITS;
			den_s4         <= NORM_ONE - sq_side.dz;
			rside_s4.ax    <= sq_side.ax;
			rside_s4.ay    <= sq_side.ay;
			rside_s4.neg_x <= sq_side.neg_x;
			rside_s4.neg_y <= sq_side.neg_y;
			rside_s4.zero  <= in_dz;
			rside_s4.mag   <= magc;
		end
	end

	rsdz_ring_div u_ring_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (val_s4),
		.in_num    (num_s4),
		.in_den    (den_s4),
		.in_side   (rside_s4),
		.res_valid (rd_valid),
		.res_q     (sm),
		.res_side  (rd_side)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			px_s5         <= 62'(rd_side.ax) * 62'(sm);
			py_s5         <= 62'(rd_side.ay) * 62'(sm);
			mag_s5        <= rd_side.mag;
			xside_s5.neg  <= rd_side.neg_x;
			xside_s5.zero <= rd_side.zero;
			yside_s5.neg  <= rd_side.neg_y;
			yside_s5.zero <= rd_side.zero;
		end
	end

	rsdz_axis_div u_div_x (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (val_s5),
		.in_prod   (px_s5),
		.in_mag    (mag_s5),
		.in_side   (xside_s5),
		.res_valid (ax_valid),
		.res_q     (qx),
		.res_side  (xs_out)
	);

	rsdz_axis_div u_div_y (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (val_s5),
		.in_prod   (py_s5),
		.in_mag    (mag_s5),
		.in_side   (yside_s5),
		.res_valid (ay_valid),
		.res_q     (qy),
		.res_side  (ys_out)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			out_x_s6 <= sat_out(qx, xs_out.neg, xs_out.zero);
			out_y_s6 <= sat_out(qy, ys_out.neg, ys_out.zero);
		end
	end

	assign out_valid = out_valid_s6;
	assign out_x     = out_x_s6;
	assign out_y     = out_y_s6;

	// the two axis dividers run in lock step
	`RSDZ_ASSERT(a_axis_lockstep, ax_valid == ay_valid, "axis dividers out of step")
	// root of a sum of two squares of at most 2^30 stays below 1.5 * 2^30
	`RSDZ_ASSERT(a_sqrt_range, sq_valid |-> (mag_raw[30:29] != 2'b11), "square root out of range")
	// the remapped length never exceeds one
	`RSDZ_ASSERT(a_scale_range, (rd_valid && !rd_side.zero) |-> (sm <= NORM_ONE), "scale above one")
	// an axis quotient never exceeds one in the output format
	`RSDZ_ASSERT(a_axis_range, (ax_valid && !xs_out.zero) |-> (32'(qx) <= (32'd1 << OUT_FRAC_BITS)), "axis above one")
	// a held output beat keeps its valid
	`RSDZ_ASSERT_NEXT(a_hold_valid, out_valid_s6 && out_stall, out_valid_s6, "held beat dropped")
endmodule
`default_nettype wire
